[rtl/core/qpu_pkg.sv]
// qpu_pkg: shared types and constants for the quaternion pose unit
// no dependencies
package qpu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 18;
  localparam int PW        = 32;
  localparam int ACC_W     = 72;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_MUL  = 3'd1;
  localparam logic [2:0] CMD_CONJ = 3'd2;
  localparam logic [2:0] CMD_ROT  = 3'd3;
  localparam logic [2:0] CMD_PT   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_QMUL, ST_QFIX, ST_MAT, ST_VEC, ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic neg;
  } mac_ctl_t;

  // round half up to FRAC_BITS, saturate to w bits, return sign-extended
  function automatic logic signed [PW-1:0] fix_sat(input logic signed [ACC_W-1:0] v,
                                                  input int w);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    s  = (v + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    hi = (ACC_W'(1) <<< (w - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (s > hi) s = hi;
    else if (s < lo) s = lo;
    return s[PW-1:0];
  endfunction

endpackage

[rtl/core/quaternion_pose_unit_top.sv]
// quaternion_pose_unit_top: sequencer, quaternion and matrix state, result register
// depends on qpu_pkg and qpu_mac
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    in_command, in_w..in_z, in_vec_*, in_org_*
//  out      out  out_valid/out_ready  out_x..out_z, out_cur_w..out_cur_z
//
// load/conjugate: q updates at the accept edge, then 9 matrix entries, each of two mac
//   terms and a rounding step, then a done state that raises the result
// multiply: 4 elements, each of four mac terms and a rounding step, then the matrix rebuild
// rotate/point: 3 elements, each of three mac terms and a rounding step, then done; unused commands go straight to done
// one item at a time: in_ready only in idle with no result waiting, so a new item is
//   not taken until the last result is accepted; a stalled result holds off the input
// reset (rst_n low, synchronous) loads q = identity and R = identity
module quaternion_pose_unit_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_command,
  input  logic signed [qpu_pkg::QW-1:0] in_w,
  input  logic signed [qpu_pkg::QW-1:0] in_x,
  input  logic signed [qpu_pkg::QW-1:0] in_y,
  input  logic signed [qpu_pkg::QW-1:0] in_z,
  input  logic signed [qpu_pkg::PW-1:0] in_vec_x,
  input  logic signed [qpu_pkg::PW-1:0] in_vec_y,
  input  logic signed [qpu_pkg::PW-1:0] in_vec_z,
  input  logic signed [qpu_pkg::PW-1:0] in_org_x,
  input  logic signed [qpu_pkg::PW-1:0] in_org_y,
  input  logic signed [qpu_pkg::PW-1:0] in_org_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [qpu_pkg::PW-1:0] out_x,
  output logic signed [qpu_pkg::PW-1:0] out_y,
  output logic signed [qpu_pkg::PW-1:0] out_z,
  output logic signed [qpu_pkg::QW-1:0] out_cur_w,
  output logic signed [qpu_pkg::QW-1:0] out_cur_x,
  output logic signed [qpu_pkg::QW-1:0] out_cur_y,
  output logic signed [qpu_pkg::QW-1:0] out_cur_z
);
  localparam int QW = qpu_pkg::QW;
  localparam int PW = qpu_pkg::PW;
  localparam logic signed [QW-1:0] ONE_Q = QW'(1 << qpu_pkg::FRAC_BITS) < 0 ?
      {1'b0, {(QW-1){1'b1}}} : QW'(1 << qpu_pkg::FRAC_BITS);

  qpu_pkg::state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;     // term index within one sum
  logic [3:0] elem_r, elem_nxt;     // result element index
  logic [2:0] cmd_r;
  logic signed [QW-1:0] q_r [4];    // w x y z
  logic signed [QW-1:0] p_r [4];    // input quaternion
  logic signed [QW-1:0] nq_r [4];   // product before writeback
  logic signed [QW-1:0] m_r [9];
  logic signed [PW+1:0] d_r [3];    // vector or point difference
  logic signed [PW-1:0] res_r [3];
  logic out_valid_r;

  qpu_pkg::mac_ctl_t ctl;
  logic signed [QW-1:0] ma;
  logic signed [PW+1:0] mb;
  logic signed [qpu_pkg::ACC_W-1:0] acc;

  qpu_mac u_mac (.clk(clk), .ctl(ctl), .a(ma), .b(mb), .acc(acc));

  // quaternion product term table: element e, term t -> p index, q index, sign
  function automatic logic [4:0] qterm(input logic [3:0] e, input logic [4:0] t);
    logic [1:0] pi, qi;
    logic ng;
    pi = t[1:0];
    ng = 1'b0;
    qi = '0;
    case (e[1:0])
      2'd0: begin qi = pi; ng = (pi != 2'd0); end
      2'd1: case (pi)
              2'd0: qi = 2'd1; 2'd1: qi = 2'd0; 2'd2: qi = 2'd3;
              default: begin qi = 2'd2; ng = 1'b1; end
            endcase
      2'd2: case (pi)
              2'd0: qi = 2'd2; 2'd2: qi = 2'd0; 2'd3: qi = 2'd1;
              default: begin qi = 2'd3; ng = 1'b1; end
            endcase
      default: case (pi)
              2'd0: qi = 2'd3; 2'd3: qi = 2'd0; 2'd1: qi = 2'd2;
              default: begin qi = 2'd1; ng = 1'b1; end
            endcase
    endcase
    return {pi, qi, ng};
  endfunction

  // matrix term table: element e, term t (0..1) -> q index a, q index b, sign
  // entries of form 2(ab +/- cd); diagonal 1 - 2(aa + bb)
  function automatic logic [4:0] mterm(input logic [3:0] e, input logic [4:0] t);
    logic [1:0] a, b;
    logic ng;
    a = '0; b = '0; ng = 1'b0;
    case (e)
      4'd0: begin a = t[0] ? 2'd3 : 2'd2; b = a; ng = 1'b1; end
      4'd1: begin a = t[0] ? 2'd3 : 2'd1; b = t[0] ? 2'd0 : 2'd2; ng = t[0]; end
      4'd2: begin a = t[0] ? 2'd2 : 2'd1; b = t[0] ? 2'd0 : 2'd3; end
      4'd3: begin a = t[0] ? 2'd3 : 2'd1; b = t[0] ? 2'd0 : 2'd2; end
      4'd4: begin a = t[0] ? 2'd3 : 2'd1; b = a; ng = 1'b1; end
      4'd5: begin a = t[0] ? 2'd1 : 2'd2; b = t[0] ? 2'd0 : 2'd3; ng = t[0]; end
      4'd6: begin a = t[0] ? 2'd2 : 2'd1; b = t[0] ? 2'd0 : 2'd3; ng = t[0]; end
      4'd7: begin a = t[0] ? 2'd1 : 2'd2; b = t[0] ? 2'd0 : 2'd3; end
      default: begin a = t[0] ? 2'd2 : 2'd1; b = a; ng = 1'b1; end
    endcase
    return {a, b, ng};
  endfunction

  logic [4:0] qt, mt;
  logic diag;
  logic [3:0] midx;
  assign qt = qterm(elem_r, step_r);
  assign mt = mterm(elem_r, step_r);
  assign diag = (elem_r == 4'd0) || (elem_r == 4'd4) || (elem_r == 4'd8);
  // rotate reads row elem, point-to-frame reads column elem
  assign midx = (cmd_r == qpu_pkg::CMD_ROT) ? 4'(elem_r * 3 + step_r[1:0])
                                            : 4'(step_r[1:0] * 3 + elem_r);

  logic signed [qpu_pkg::ACC_W-1:0] mat_acc;
  logic signed [PW-1:0] fixed;
  always_comb begin
    // diagonal adds one at scale 2^2F; all sums doubled
    mat_acc = (acc <<< 1) + (diag ? (qpu_pkg::ACC_W'(1) <<< (2 * qpu_pkg::FRAC_BITS)) : '0);
    if (state_r == qpu_pkg::ST_VEC) fixed = qpu_pkg::fix_sat(acc, PW);
    else if (state_r == qpu_pkg::ST_MAT) fixed = qpu_pkg::fix_sat(mat_acc, QW);
    else fixed = qpu_pkg::fix_sat(acc, QW);
  end

  logic last_term;
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    elem_nxt = elem_r;
    ctl = '{clr: 1'b0, en: 1'b0, neg: 1'b0};
    ma = '0;
    mb = '0;
    last_term = 1'b0;
    case (state_r)
      qpu_pkg::ST_IDLE: begin
        if (in_valid && !out_valid_r) begin
          step_nxt = '0;
          elem_nxt = '0;
          case (in_command)
            qpu_pkg::CMD_LOAD, qpu_pkg::CMD_CONJ: state_nxt = qpu_pkg::ST_MAT;
            qpu_pkg::CMD_MUL: state_nxt = qpu_pkg::ST_QMUL;
            qpu_pkg::CMD_ROT, qpu_pkg::CMD_PT: state_nxt = qpu_pkg::ST_VEC;
            default: state_nxt = qpu_pkg::ST_DONE;
          endcase
        end
      end
      qpu_pkg::ST_QMUL: begin
        ma = p_r[qt[4:3]];
        mb = (PW+2)'(q_r[qt[2:1]]);
        ctl = '{clr: (step_r == 5'd0), en: 1'b1, neg: qt[0]};
        last_term = (step_r == 5'd3);
        step_nxt = last_term ? 5'd0 : step_r + 5'd1;
        // a bubble state (ST_QFIX) per element writes the rounded sum
        if (last_term) state_nxt = qpu_pkg::ST_QFIX;
      end
      qpu_pkg::ST_QFIX: begin
        elem_nxt = elem_r + 4'd1;
        state_nxt = (elem_r == 4'd3) ? qpu_pkg::ST_MAT : qpu_pkg::ST_QMUL;
        if (elem_r == 4'd3) elem_nxt = '0;
      end
      qpu_pkg::ST_MAT: begin
        if (step_r != 5'd2) begin
          ma = q_r[mt[4:3]];
          mb = (PW+2)'(q_r[mt[2:1]]);
          ctl = '{clr: (step_r == 5'd0), en: 1'b1, neg: mt[0]};
        end
        last_term = (step_r == 5'd2);
        step_nxt = last_term ? 5'd0 : step_r + 5'd1;
        if (last_term) begin
          elem_nxt = elem_r + 4'd1;
          if (elem_r == 4'd8) state_nxt = qpu_pkg::ST_DONE;
        end
      end
      qpu_pkg::ST_VEC: begin
        if (step_r != 5'd3) begin
          ma = m_r[midx];
          mb = d_r[step_r[1:0]];
          ctl = '{clr: (step_r == 5'd0), en: 1'b1, neg: 1'b0};
        end
        last_term = (step_r == 5'd3);
        step_nxt = last_term ? 5'd0 : step_r + 5'd1;
        if (last_term) begin
          elem_nxt = elem_r + 4'd1;
          if (elem_r == 4'd2) state_nxt = qpu_pkg::ST_DONE;
        end
      end
      qpu_pkg::ST_DONE: state_nxt = qpu_pkg::ST_IDLE;
      default: state_nxt = qpu_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == qpu_pkg::ST_IDLE) && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qpu_pkg::ST_IDLE;
      step_r <= '0;
      elem_r <= '0;
      out_valid_r <= 1'b0;
      q_r[0] <= ONE_Q;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      elem_r <= elem_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == qpu_pkg::ST_DONE) out_valid_r <= 1'b1;
      if (in_valid && in_ready) begin
        if (in_command == qpu_pkg::CMD_LOAD) begin
          q_r[0] <= in_w; q_r[1] <= in_x; q_r[2] <= in_y; q_r[3] <= in_z;
        end else if (in_command == qpu_pkg::CMD_CONJ) begin
          for (int i = 1; i < 4; i++) begin
            q_r[i] <= (q_r[i] == {1'b1, {(QW-1){1'b0}}}) ? {1'b0, {(QW-1){1'b1}}}
                                                        : -q_r[i];
          end
        end
      end
      if (state_r == qpu_pkg::ST_QFIX && elem_r == 4'd3) begin
        q_r[0] <= nq_r[0]; q_r[1] <= nq_r[1]; q_r[2] <= nq_r[2];
        q_r[3] <= fixed[QW-1:0];
      end
      if (state_r == qpu_pkg::ST_MAT && last_term) m_r[elem_r] <= fixed[QW-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      p_r[0] <= in_w; p_r[1] <= in_x; p_r[2] <= in_y; p_r[3] <= in_z;
      if (in_command == qpu_pkg::CMD_PT) begin
        d_r[0] <= (PW+2)'(in_vec_x) - (PW+2)'(in_org_x);
        d_r[1] <= (PW+2)'(in_vec_y) - (PW+2)'(in_org_y);
        d_r[2] <= (PW+2)'(in_vec_z) - (PW+2)'(in_org_z);
      end else begin
        d_r[0] <= (PW+2)'(in_vec_x);
        d_r[1] <= (PW+2)'(in_vec_y);
        d_r[2] <= (PW+2)'(in_vec_z);
      end
      for (int i = 0; i < 3; i++) res_r[i] <= '0;
    end
    if (state_r == qpu_pkg::ST_QFIX) nq_r[elem_r[1:0]] <= fixed[QW-1:0];
    if (state_r == qpu_pkg::ST_VEC && last_term) res_r[elem_r[1:0]] <= fixed;
  end

  assign out_valid = out_valid_r;
  assign out_x = res_r[0];
  assign out_y = res_r[1];
  assign out_z = res_r[2];
  assign out_cur_w = q_r[0];
  assign out_cur_x = q_r[1];
  assign out_cur_y = q_r[2];
  assign out_cur_z = q_r[3];

  // no new beat while a result waits
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // a result follows the done state
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qpu_pkg::ST_DONE |=> out_valid) else $error("result missing");
  // stored quaternion w and z hold while a result is offered and not taken
  a_q_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cur_w) && $stable(out_cur_z))
    else $error("quaternion changed under a pending result");
endmodule

[rtl/core/qpu_mac.sv]
// qpu_mac: shared multiply-accumulate unit, one 18x34 product per cycle
// depends on qpu_pkg
module qpu_mac (
  input  logic                                clk,
  input  qpu_pkg::mac_ctl_t                   ctl,
  input  logic signed [qpu_pkg::QW-1:0]       a,
  input  logic signed [qpu_pkg::PW+1:0]       b,
  output logic signed [qpu_pkg::ACC_W-1:0]    acc
);
  logic signed [qpu_pkg::ACC_W-1:0] acc_r, acc_nxt, prod;
  logic signed [qpu_pkg::QW+qpu_pkg::PW+1:0] prod_s;

  always_comb begin
    // exact 18x34 signed product, then sign-extended into the accumulator
    prod_s = a * b;
    prod = qpu_pkg::ACC_W'(prod_s);
    acc_nxt = ctl.clr ? '0 : acc_r;
    if (ctl.en) begin
      acc_nxt = ctl.neg ? acc_nxt - prod : acc_nxt + prod;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule
